>>> rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Box and result structs, register reset value, store defaults.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int unsigned DefMaxKept       = 256;
  localparam int unsigned DefMaxCandidates = 1024;
  localparam logic [15:0] IouThresholdRst  = 16'd29491;
  localparam int unsigned IdxW             = 10;

  typedef struct packed {
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic        [14:0] box_width;
    logic        [14:0] box_height;
    logic               set_end;
  } box_req_t;

  typedef struct packed {
    logic            kept;
    logic [IdxW-1:0] candidate_index;
    logic            store_overflow;
    logic            set_last;
  } box_res_t;

  // classified request handed from front to back
  typedef struct packed {
    box_req_t        box;
    logic [IdxW-1:0] idx;
    logic            idx_ovf;
  } box_job_t;

endpackage

>>> rtl/gbs_front.sv
// ----------------------------------------------------------------------------
// gbs_front: request intake
// Numbers candidates within a set and queues them for the compare engine.
// ----------------------------------------------------------------------------
module gbs_front #(
  parameter int unsigned MaxCandidates = gbs_pkg::DefMaxCandidates
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  gbs_pkg::box_req_t  req_i,
  output logic               job_valid_o,
  input  logic               job_take_i,
  output gbs_pkg::box_job_t  job_o
);
  localparam int unsigned CntW = $clog2(MaxCandidates + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxCandidates);
  localparam logic [CntW-1:0] IdxLast = CntW'(MaxCandidates - 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  gbs_pkg::box_job_t q_mem_q [2];
  logic [0:0] wr_q, rd_q;
  logic [1:0] fill_q;
  gbs_pkg::box_job_t job_new;
  logic sat, wr_en, rd_en;

  assign full  = (fill_q == 2'd2);
  assign wr_en = push && !full;
  assign rd_en = job_take_i && (fill_q != 2'd0);
  assign sat   = (cnt_q == CntMax);
  assign job_valid_o = (fill_q != 2'd0);
  assign job_o = q_mem_q[rd_q];

  always_comb begin
    logic [CntW-1:0] idx_full;
    idx_full = sat ? IdxLast : cnt_q;
    job_new.box     = req_i;
    job_new.idx     = gbs_pkg::IdxW'(idx_full);
    job_new.idx_ovf = sat;
    cnt_d = cnt_q;
    if (wr_en) begin
      if (req_i.set_end) cnt_d = '0;
      else if (!sat) cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) q_mem_q[wr_q] <= job_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      fill_q <= fill_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

>>> rtl/gbs_back.sv
// ----------------------------------------------------------------------------
// gbs_back: compare engine
// Walks the kept store one entry per step, pipelined; stores survivors.
// ----------------------------------------------------------------------------
module gbs_back #(
  parameter int unsigned MaxKept = gbs_pkg::DefMaxKept
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        thr_i,
  input  logic               job_valid_i,
  output logic               job_take_o,
  input  gbs_pkg::box_job_t  job_i,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output gbs_pkg::box_res_t  res_o,
  output logic               busy_o
);
  localparam int unsigned AW = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int unsigned KW = $clog2(MaxKept + 1);
  localparam logic [KW-1:0] KMax = KW'(MaxKept);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q;
  gbs_pkg::box_job_t job_q;
  logic [29:0] area_q;
  logic [KW-1:0] kcnt_q;
  logic [KW-1:0] rd_idx_q;
  logic supp_q;

  logic [61:0] box_mem [MaxKept];
  logic [29:0] area_mem [MaxKept];

  // stage 1: memory read
  logic        s1_v_q;
  logic [61:0] s1_box_q;
  logic [29:0] s1_area_q;
  // stage 2: overlaps
  logic        s2_v_q;
  logic [16:0] s2_ow_q, s2_oh_q;
  logic [29:0] s2_area_q;
  // stage 3: intersection
  logic        s3_v_q;
  logic [33:0] s3_int_q;
  logic [30:0] s3_uni_q;
  // stage 4: scaled products
  logic        s4_v_q;
  logic [49:0] s4_lhs_q;
  logic [46:0] s4_rhs_q;

  gbs_pkg::box_res_t res_q;
  logic res_v_q;

  function automatic logic [16:0] ovl(input logic signed [15:0] a0,
                                       input logic [14:0] al,
                                       input logic signed [15:0] b0,
                                       input logic [14:0] bl);
    logic signed [17:0] lo, hi, ea, eb, d;
    lo = (a0 > b0) ? 18'(a0) : 18'(b0);
    ea = 18'(a0) + 18'($signed({1'b0, al}));
    eb = 18'(b0) + 18'($signed({1'b0, bl}));
    hi = (ea < eb) ? ea : eb;
    d  = hi - lo;
    return (hi > lo) ? d[16:0] : 17'd0;
  endfunction

  logic issue;
  assign issue = (state_q == S_SCAN) && (rd_idx_q < kcnt_q);
  assign job_take_o = (state_q == S_IDLE) && job_valid_i;
  assign res_valid_o = res_v_q;
  assign res_o = res_q;
  assign busy_o = (state_q != S_IDLE) || s1_v_q || s4_v_q;

  logic pipe_empty;
  assign pipe_empty = !s1_v_q && !s2_v_q && !s3_v_q && !s4_v_q;

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      job_q  <= job_i;
      area_q <= job_i.box.box_width * job_i.box.box_height;
    end
    if (issue) begin
      s1_box_q  <= box_mem[rd_idx_q[AW-1:0]];
      s1_area_q <= area_mem[rd_idx_q[AW-1:0]];
    end
    s2_ow_q <= ovl(job_q.box.box_left, job_q.box.box_width,
                   s1_box_q[15:0], s1_box_q[46:32]);
    s2_oh_q <= ovl(job_q.box.box_top, job_q.box.box_height,
                   s1_box_q[31:16], s1_box_q[61:47]);
    s2_area_q <= s1_area_q;
    s3_int_q <= 34'(s2_ow_q) * 34'(s2_oh_q);
    s3_uni_q <= 31'(area_q) + 31'(s2_area_q)
              - 31'(34'(s2_ow_q) * 34'(s2_oh_q));
    s4_lhs_q <= {s3_int_q[33:0], 16'd0};
    s4_rhs_q <= 47'(thr_i) * 47'(s3_uni_q);
    if (state_q == S_DONE && kcnt_q < KMax && !supp_q) begin
      box_mem[kcnt_q[AW-1:0]]  <= {job_q.box.box_height, job_q.box.box_width,
                                   job_q.box.box_top, job_q.box.box_left};
      area_mem[kcnt_q[AW-1:0]] <= area_q;
    end
    if (state_q == S_DONE && !res_v_q) begin
      res_q.kept            <= !supp_q;
      res_q.candidate_index <= job_q.idx;
      res_q.store_overflow  <= job_q.idx_ovf || (!supp_q && kcnt_q == KMax);
      res_q.set_last        <= job_q.box.set_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kcnt_q   <= '0;
      rd_idx_q <= '0;
      supp_q   <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      if (s4_v_q && (s4_lhs_q > 50'(s4_rhs_q))) supp_q <= 1'b1;
      if (res_take_i && res_v_q) res_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (job_take_o) begin
            state_q  <= S_SCAN;
            rd_idx_q <= '0;
            supp_q   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (issue) rd_idx_q <= rd_idx_q + 1'b1;
          else state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (pipe_empty) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!res_v_q) begin
            res_v_q <= 1'b1;
            state_q <= S_IDLE;
            if (job_q.box.set_end) kcnt_q <= '0;
            else if (!supp_q && kcnt_q < KMax) kcnt_q <= kcnt_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression: greedy non-maximum suppression by overlap ratio
// Queue-style intake, kept-box compare engine, one result per candidate.
// ----------------------------------------------------------------------------
// For each candidate, the compare engine reads the k boxes kept so far in its
// set from its store, one kept box per cycle, through a four-stage overlap
// pipeline, and the next candidate is taken once its result is posted. A
// two-entry queue lets pushes continue while the engine works, and a result
// register holds the answer until popped. The threshold may be written
// only while the block is idle.
module greedy_box_suppression #(
  parameter int unsigned MaxKept       = gbs_pkg::DefMaxKept,
  parameter int unsigned MaxCandidates = gbs_pkg::DefMaxCandidates
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  gbs_pkg::box_req_t req_i,
  output logic              empty,
  input  logic              pop,
  output gbs_pkg::box_res_t res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i
);
  logic [15:0] thr_q;
  logic job_valid, job_take, res_valid, busy;
  gbs_pkg::box_job_t job;

  assign cfg_ready_o = 1'b1;
  assign empty = !res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= gbs_pkg::IouThresholdRst;
    else if (cfg_valid_i) thr_q <= cfg_data_i;
  end

  gbs_front #(.MaxCandidates(MaxCandidates)) u_front (
    .clk_i, .rst_ni, .push, .full, .req_i,
    .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  gbs_back #(.MaxKept(MaxKept)) u_back (
    .clk_i, .rst_ni, .thr_i(thr_q),
    .job_valid_i(job_valid), .job_take_o(job_take), .job_i(job),
    .res_valid_o(res_valid), .res_take_i(pop), .res_o, .busy_o(busy)
  );

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |-> job_valid) else $error("job taken from empty queue");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o))) else $error("result lost");
  a_busy_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |=> busy) else $error("engine not busy after take");
endmodule

>>> verif/greedy_box_suppression_tb.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb: self-checking bench for greedy box suppression
// Drives candidate sets through the push/full queue, pops results with random
// stalls, and checks each result against a cycle-free model of the kept store.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module greedy_box_suppression_tb;

  localparam int unsigned MaxKept  = gbs_pkg::DefMaxKept;
  localparam int unsigned MaxCand  = gbs_pkg::DefMaxCandidates;
  localparam int unsigned WdogMax  = 20000;
  localparam int unsigned DrainCyc = 600;

  class nms_scoreboard;
    logic [63:0] boxes_q[MaxKept];
    logic [29:0] areas_q[MaxKept];
    int unsigned n_kept;
    int unsigned n_seen;
    logic [15:0] thresh;
    gbs_pkg::box_res_t pending_q[$];
    int unsigned n_err;

    function void clear();
      n_kept = 0;
      n_seen = 0;
      thresh = gbs_pkg::IouThresholdRst;
      pending_q.delete();
      n_err = 0;
    endfunction

    function longint overlap(longint a0, longint al, longint b0, longint bl);
      longint lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
      return (hi > lo) ? hi - lo : 0;
    endfunction

    // suppression decision for one accepted request
    function void note_request(gbs_pkg::box_req_t r);
      longint l, t, w, h, inter, uni;
      longint unsigned area;
      logic [63:0] b;
      bit keep;
      gbs_pkg::box_res_t e;
      l = r.box_left;
      t = r.box_top;
      w = r.box_width;
      h = r.box_height;
      area = w * h;
      keep = 1'b1;
      for (int j = 0; j < n_kept; j++) begin
        b = boxes_q[j];
        inter = overlap(l, w, longint'($signed(b[15:0])), longint'(b[46:32])) *
                overlap(t, h, longint'($signed(b[31:16])), longint'(b[61:47]));
        uni = area + areas_q[j] - inter;
        if (inter * 65536 > longint'(thresh) * uni) keep = 1'b0;
      end
      e = '0;
      if (n_seen >= MaxCand) begin
        e.candidate_index = gbs_pkg::IdxW'(MaxCand - 1);
        e.store_overflow = 1'b1;
      end else begin
        e.candidate_index = gbs_pkg::IdxW'(n_seen);
        n_seen++;
      end
      if (keep) begin
        if (n_kept < MaxKept) begin
          boxes_q[n_kept] = {2'b00, r.box_height, r.box_width, r.box_top, r.box_left};
          areas_q[n_kept] = area[29:0];
          n_kept++;
        end else e.store_overflow = 1'b1;
      end
      e.kept = keep;
      e.set_last = r.set_end;
      pending_q = {pending_q, e};
      if (r.set_end) begin
        n_kept = 0;
        n_seen = 0;
      end
    endfunction

    function void check_result(gbs_pkg::box_res_t a);
      gbs_pkg::box_res_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result %p", a);
        n_err++;
        return;
      end
      e = pending_q.pop_front();
      if (a.kept !== e.kept) begin
        $error("kept: expected %0d actual %0d", e.kept, a.kept);
        n_err++;
      end
      if (a.candidate_index !== e.candidate_index) begin
        $error("candidate_index: expected %0d actual %0d", e.candidate_index,
               a.candidate_index);
        n_err++;
      end
      if (a.store_overflow !== e.store_overflow) begin
        $error("store_overflow: expected %0d actual %0d", e.store_overflow,
               a.store_overflow);
        n_err++;
      end
      if (a.set_last !== e.set_last) begin
        $error("set_last: expected %0d actual %0d", e.set_last, a.set_last);
        n_err++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  gbs_pkg::box_req_t req_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  gbs_pkg::box_res_t res_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [15:0]       cfg_data_i = '0;

  nms_scoreboard sb;
  int unsigned   idle_cycles;
  bit            stall_free;

  greedy_box_suppression uut (
    .clk_i, .rst_ni, .push, .full, .req_i, .empty, .pop, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: random pop stalls, check on accepted pops
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(res_o);
      pop <= stall_free || ($urandom_range(99) >= 32);
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)
        || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogMax) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // push stays high after an accepted request so requests can follow back to back
  task automatic send_box(gbs_pkg::box_req_t r);
    while (!stall_free && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_thresh(logic [15:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.thresh = v;
  endtask

  function automatic gbs_pkg::box_req_t mk_box(int l, int t, int w, int h, bit e);
    gbs_pkg::box_req_t r;
    r.box_left = 16'(l);
    r.box_top = 16'(t);
    r.box_width = 15'(w);
    r.box_height = 15'(h);
    r.set_end = e;
    return r;
  endfunction

  // clustered boxes so overlaps are common; occasionally full-range noise
  function automatic gbs_pkg::box_req_t rand_box(bit e);
    gbs_pkg::box_req_t r;
    if ($urandom_range(9) == 0) begin
      r = gbs_pkg::box_req_t'($urandom());
      r.box_width = 15'($urandom());
      r.box_left = 16'($urandom());
    end else begin
      r = mk_box($urandom_range(600) - 300, $urandom_range(600) - 300,
                 $urandom_range(400), $urandom_range(400), 1'b0);
    end
    r.set_end = e;
    return r;
  endfunction

  initial begin
    int unsigned n_sent, len;
    sb = new();
    sb.clear();
    stall_free = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, identical boxes, zero areas, disjoint boxes
    send_box(mk_box(0, 0, 160, 160, 0));
    send_box(mk_box(0, 0, 160, 160, 0));
    send_box(mk_box(16, 16, 160, 160, 0));
    send_box(mk_box(1000, 1000, 0, 0, 0));
    send_box(mk_box(1000, 1000, 0, 0, 0));
    send_box(mk_box(-32768, -32768, 32767, 32767, 0));
    send_box(mk_box(32767, 32767, 32767, 32767, 0));
    send_box(mk_box(-32768, 32767, 0, 32767, 0));
    send_box(mk_box(-1, -1, 32767, 1, 1));
    write_thresh(16'd0);
    send_box(mk_box(0, 0, 10, 10, 0));
    send_box(mk_box(9, 9, 10, 10, 0));
    send_box(mk_box(10, 0, 10, 10, 1));
    write_thresh(16'hFFFF);
    send_box(mk_box(0, 0, 10, 10, 0));
    send_box(mk_box(0, 0, 10, 10, 1));
    write_thresh(16'd32768);

    // store full: disjoint boxes beyond the store depth
    for (int i = 0; i < MaxKept + 8; i++)
      send_box(mk_box(-32768 + (i % 128) * 512, -32768 + (i / 128) * 512,
                      16, 16, i == MaxKept + 7));
    wait_drained();

    // random sets, mostly short, a stretch without any stalls
    n_sent = 0;
    while (n_sent < 120) begin
      if (n_sent > 30 && n_sent < 90) stall_free = 1'b1;
      else stall_free = 1'b0;
      if (n_sent > 0 && $urandom_range(7) == 0)
        write_thresh(($urandom_range(3) == 0) ? 16'($urandom()) :
                     16'($urandom_range(52000, 13000)));
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) send_box(rand_box(i == len - 1));
      n_sent += len;
    end
    stall_free = 1'b0;
    write_thresh(gbs_pkg::IouThresholdRst);
    for (int i = 0; i < 6; i++) send_box(rand_box(i == 5));
    wait_drained();

    repeat (DrainCyc) @(posedge clk_i);
    if (sb.n_err == 0 && sb.pending_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
